[hw/rtl/assert_macros.svh]
// Assertion macros for the cooling-rate lookup RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

[hw/rtl/crbl_pkg.sv]
// Package for the cooling-rate bilinear lookup: constants, codes, tables.
// No dependencies.
package crbl_pkg;

   localparam int TEMP_POINTS_DEF = 91;
   localparam int METAL_ROWS_DEF  = 8;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic signed [21:0] LOGT_MIN     = 22'sd262144;
   localparam logic signed [18:0] LOG2_TEN_Q16 = 19'sd217706;
   localparam logic signed [61:0] RATE_MAX     = 62'sd4194303;
   localparam logic signed [61:0] RATE_MIN     = -62'sd4194304;
   localparam logic [31:0]        FLOAT_INF    = 32'h7F80_0000;

   // metallicity breakpoints: [Fe/H] plus log10(0.02), Q16
   typedef logic signed [20:0] bp_tab_type [0:7];
   localparam bp_tab_type Z_BREAK = '{
      -21'sd439024, -21'sd307952, -21'sd242416, -21'sd209648,
      -21'sd176880, -21'sd144112, -21'sd111344, -21'sd78576
   };

   function automatic logic [4:0] span_shift(input logic [2:0] idx);
      logic [4:0] sh;
      case (idx)
         3'd0:    sh = 5'd17;
         3'd1:    sh = 5'd16;
         default: sh = 5'd15;
      endcase
      return sh;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] bv;
      logic [63:0] xv;
      r  = '0;
      xv = x;
      bv = 64'h4000_0000_0000_0000;
      for (int n = 0; n < 32; n++) begin
         if (xv >= r + bv) begin
            xv = xv - (r + bv);
            r  = (r >> 1) + bv;
         end else begin
            r = r >> 1;
         end
         bv = bv >> 2;
      end
      return r;
   endfunction

   // 2^(k/64) in Q23, k = 0..64
   typedef logic [24:0] pow_tab_type [0:64];

   function automatic pow_tab_type build_pow_tab();
      pow_tab_type t;
      logic [63:0] q [0:5];
      logic [63:0] acc;
      q[5] = isqrt64(64'd1 << 61);
      for (int j = 5; j > 0; j--) begin
         q[j-1] = isqrt64(q[j] << 30);
      end
      for (int k = 0; k < 64; k++) begin
         acc = 64'd1 << 30;
         for (int j = 0; j < 6; j++) begin
            if (k[j]) begin
               acc = (acc * q[j]) >> 30;
            end
         end
         t[k] = 25'((acc + 64'd64) >> 7);
      end
      t[64] = 25'd1 << 24;
      return t;
   endfunction

   localparam pow_tab_type POW_TAB = build_pow_tab();

endpackage

[hw/rtl/cooling_rate_bilinear_lookup.sv]
// Cooling-rate bilinear lookup: table storage, sequencer, one shared multiplier.
// Depends on crbl_pkg and assert_macros.svh.
//
// Command-style block. A word is taken when start is high and busy is low.
// Mode 0 writes one table entry (row, column) in the accept cycle and is done;
// writing the last entry (last row, last column) marks the table ready and
// further loads are dropped until a mode 2 word clears the flag (the stored
// entries stay). Mode 3 does nothing. Neither loads, clears nor mode 3 give a
// result, and none of them raise busy.
// A mode 1 query gives exactly one result word, shown for one cycle with
// rsp_valid high; the receiver cannot stall, so the result must be taken then.
// Before the table is ready a query returns rate 0, float bits 0 and
// rsp_not_ready = 1 in the cycle after acceptance, with busy staying low.
// A ready query runs from acceptance through the states PREP, READ, T1 to MANT
// and OUT to the result strobe (busy in all of them; the next query can be
// accepted in the strobe cycle): bin/bracket setup in PREP, reading the four
// corner entries through the single registered port of the table memory in
// READ, then T1 to MANT, in which one signed multiplier is reused for the two
// temperature interpolations, the metallicity interpolation, the log2(10)
// scaling and the mantissa interpolation, and OUT, which assembles the float
// word into the result registers. Temperatures above the last bin extrapolate
// from the last pair; log Z is clamped to the outer breakpoints; the rate is
// saturated to 23 bits and the float underflows to 0 and overflows to infinity.
// Reading an entry that was never written gives an undefined result.
`include "assert_macros.svh"

module cooling_rate_bilinear_lookup #(
   parameter int TEMP_POINTS = crbl_pkg::TEMP_POINTS_DEF,
   parameter int METAL_ROWS  = crbl_pkg::METAL_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [2:0]         req_table_row,
   input  logic [6:0]         req_table_col,
   input  logic signed [22:0] req_entry_value,
   input  logic signed [20:0] req_log_temp,
   input  logic signed [20:0] req_log_z,
   output logic               rsp_valid,
   output logic signed [22:0] rsp_log_rate,
   output logic [31:0]        rsp_rate_float_bits,
   output logic               rsp_not_ready
);
   import crbl_pkg::*;

   localparam int DEPTH = METAL_ROWS * TEMP_POINTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int BW    = $clog2(TEMP_POINTS);

   // sequencer codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PREP = 4'd1;
   localparam logic [3:0] S_READ = 4'd2;
   localparam logic [3:0] S_T1   = 4'd3;
   localparam logic [3:0] S_T2   = 4'd4;
   localparam logic [3:0] S_T3   = 4'd5;
   localparam logic [3:0] S_Z    = 4'd6;
   localparam logic [3:0] S_SAT  = 4'd7;
   localparam logic [3:0] S_F    = 4'd8;
   localparam logic [3:0] S_Y    = 4'd9;
   localparam logic [3:0] S_MANT = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  rd_cnt_ff, rd_cnt_in;
   logic        ready_ff, ready_in;

   logic signed [20:0] lt_ff, lz_ff;
   logic [BW-1:0]      bin_ff;
   logic [24:0]        frac_ff;
   logic [2:0]         row_ff;
   logic signed [18:0] off_ff;
   logic [4:0]         shift_ff;

   logic signed [22:0] mem [0:DEPTH-1];
   logic signed [22:0] rd_data_ff;
   logic signed [22:0] ent_ff [0:3];

   logic signed [60:0] prod_ff;
   logic signed [33:0] r1_ff, r2_ff;
   logic signed [22:0] rate_ff;
   logic signed [24:0] y_ff;

   logic               rsp_valid_ff;
   logic signed [22:0] rsp_rate_ff;
   logic [31:0]        rsp_bits_ff;
   logic               rsp_nr_ff;

   logic accept;
   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // ---------------- setup math (bin, fraction, bracket) ----------------
   logic signed [21:0] d_s;
   logic [20:0]        d_u;
   logic [24:0]        s_u;
   logic [8:0]         bin_raw;
   logic [BW-1:0]      bin_c;
   logic [24:0]        frac_c;
   logic signed [20:0] lz_c;
   logic [2:0]         row_c;

   always_comb begin
      d_s = 22'(lt_ff) - LOGT_MIN;
      d_u = d_s[21] ? '0 : d_s[20:0];
      s_u = (25'(d_u) << 4) + (25'(d_u) << 2);
      bin_raw = s_u[24:16];
      if (bin_raw > 9'(TEMP_POINTS - 2)) begin
         bin_c = BW'(TEMP_POINTS - 2);
      end else begin
         bin_c = BW'(bin_raw);
      end
      frac_c = s_u - (25'(bin_c) << 16);

      lz_c = lz_ff;
      if (lz_c < Z_BREAK[0]) lz_c = Z_BREAK[0];
      if (lz_c > Z_BREAK[METAL_ROWS-1]) lz_c = Z_BREAK[METAL_ROWS-1];
      row_c = '0;
      for (int j = 1; j < METAL_ROWS - 1; j++) begin
         if (lz_c > Z_BREAK[j]) row_c = row_c + 3'd1;
      end
   end

   // ---------------- table addressing ----------------
   logic [AW:0]   base;
   logic [AW:0]   rd_sum;
   logic [AW-1:0] rd_addr;
   logic [AW:0]   wr_sum;
   logic          wr_en;

   always_comb begin
      base = (AW+1)'(row_ff) * (AW+1)'(TEMP_POINTS) + (AW+1)'(bin_ff);
      case (rd_cnt_ff[1:0])
         2'd0:    rd_sum = base;
         2'd1:    rd_sum = base + (AW+1)'(1);
         2'd2:    rd_sum = base + (AW+1)'(TEMP_POINTS);
         default: rd_sum = base + (AW+1)'(TEMP_POINTS + 1);
      endcase
      rd_addr = rd_sum[AW-1:0];
      wr_sum  = (AW+1)'(req_table_row) * (AW+1)'(TEMP_POINTS)
              + (AW+1)'(req_table_col);
      wr_en   = accept && (req_mode == MODE_LOAD) && !ready_ff
              && (32'(req_table_row) < METAL_ROWS)
              && (32'(req_table_col) < TEMP_POINTS);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_sum[AW-1:0]] <= req_entry_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // ---------------- shared multiplier ----------------
   logic signed [34:0] mul_a;
   logic signed [25:0] mul_b;
   logic signed [60:0] mul_p;
   logic [5:0]         k_idx;
   logic [9:0]         u_frac;
   logic [24:0]        p0, p1;

   assign k_idx  = y_ff[15:10];
   assign u_frac = y_ff[9:0];
   assign p0     = POW_TAB[k_idx];
   assign p1     = POW_TAB[7'(k_idx) + 7'd1];

   always_comb begin
      case (state_ff)
         S_T1: begin
            mul_a = 35'(ent_ff[1]) - 35'(ent_ff[0]);
            mul_b = 26'({1'b0, frac_ff});
         end
         S_T2: begin
            mul_a = 35'(ent_ff[3]) - 35'(ent_ff[2]);
            mul_b = 26'({1'b0, frac_ff});
         end
         S_Z: begin
            mul_a = 35'(r2_ff) - 35'(r1_ff);
            mul_b = 26'(off_ff);
         end
         S_F: begin
            mul_a = 35'(rate_ff);
            mul_b = 26'(LOG2_TEN_Q16);
         end
         S_MANT: begin
            mul_a = 35'({1'b0, u_frac});
            mul_b = 26'({1'b0, p1 - p0});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = 61'(mul_a) * 61'(mul_b);
   end

   // ---------------- result assembly ----------------
   logic signed [61:0] z_sum;
   logic signed [22:0] rate_sat;
   logic signed [9:0]  e_b;
   logic [24:0]        mant;
   logic [31:0]        fbits;

   always_comb begin
      z_sum = 62'(r1_ff) + (62'(prod_ff) >>> shift_ff);
      if (z_sum > RATE_MAX) begin
         rate_sat = 23'(RATE_MAX);
      end else if (z_sum < RATE_MIN) begin
         rate_sat = 23'(RATE_MIN);
      end else begin
         rate_sat = 23'(z_sum);
      end
      e_b  = 10'(y_ff >>> 16) + 10'sd127;
      mant = p0 + 25'(prod_ff >>> 10);
      if (e_b <= 10'sd0) begin
         fbits = '0;
      end else if (e_b >= 10'sd255) begin
         fbits = FLOAT_INF;
      end else begin
         fbits = {1'b0, e_b[7:0], mant[22:0]};
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      rd_cnt_in = rd_cnt_ff;
      ready_in  = ready_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_LOAD: begin
                     if (wr_en && (32'(req_table_row) == METAL_ROWS - 1)
                         && (32'(req_table_col) == TEMP_POINTS - 1)) begin
                        ready_in = 1'b1;
                     end
                  end
                  MODE_QUERY: begin
                     if (ready_ff) state_in = S_PREP;
                  end
                  MODE_CLEAR: ready_in = 1'b0;
                  default: ;
               endcase
            end
         end
         S_PREP: begin
            state_in  = S_READ;
            rd_cnt_in = '0;
         end
         S_READ: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == 3'd4) state_in = S_T1;
         end
         S_T1:    state_in = S_T2;
         S_T2:    state_in = S_T3;
         S_T3:    state_in = S_Z;
         S_Z:     state_in = S_SAT;
         S_SAT:   state_in = S_F;
         S_F:     state_in = S_Y;
         S_Y:     state_in = S_MANT;
         S_MANT:  state_in = S_OUT;
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_cnt_ff    <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= (accept && (req_mode == MODE_QUERY) && !ready_ff)
                      || (state_ff == S_OUT);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         lt_ff <= req_log_temp;
         lz_ff <= req_log_z;
      end
      if (state_ff == S_PREP) begin
         bin_ff   <= bin_c;
         frac_ff  <= frac_c;
         row_ff   <= row_c;
         off_ff   <= 19'(lz_c) - 19'(Z_BREAK[row_c]);
         shift_ff <= span_shift(row_c);
      end
      if (state_ff == S_READ && rd_cnt_ff != 3'd0) begin
         ent_ff[rd_cnt_ff[1:0] - 2'd1] <= rd_data_ff;
      end
      case (state_ff)
         S_T1, S_T2, S_Z, S_F, S_MANT: prod_ff <= mul_p;
         default: ;
      endcase
      if (state_ff == S_T2) r1_ff <= 34'(ent_ff[0]) + 34'(prod_ff >>> 16);
      if (state_ff == S_T3) r2_ff <= 34'(ent_ff[2]) + 34'(prod_ff >>> 16);
      if (state_ff == S_SAT) rate_ff <= rate_sat;
      if (state_ff == S_Y) y_ff <= 25'(prod_ff >>> 16);
      if (accept && (req_mode == MODE_QUERY) && !ready_ff) begin
         rsp_rate_ff <= '0;
         rsp_bits_ff <= '0;
         rsp_nr_ff   <= 1'b1;
      end else if (state_ff == S_OUT) begin
         rsp_rate_ff <= rate_ff;
         rsp_bits_ff <= fbits;
         rsp_nr_ff   <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_log_rate        = rsp_rate_ff;
   assign rsp_rate_float_bits = rsp_bits_ff;
   assign rsp_not_ready       = rsp_nr_ff;

   // ---------------- assertions ----------------
   `ASSERT_CLK(a_prep_from_query, clock, reset,
      (state_ff == S_PREP) |-> $past(accept && req_mode == MODE_QUERY && ready_ff),
      "sequencer left idle without a ready query")
   `ASSERT_CLK(a_rd_cnt_bound, clock, reset,
      (state_ff == S_READ) |-> (rd_cnt_ff <= 3'd4),
      "table read counter overran")
   `ASSERT_CLK(a_nr_zero, clock, reset,
      (rsp_valid && rsp_not_ready) |-> (rsp_log_rate == 0 && rsp_rate_float_bits == 0),
      "not-ready result carries data")
   `ASSERT_CLK(a_out_strobe, clock, reset,
      (state_ff == S_OUT) |=> (rsp_valid && !rsp_not_ready),
      "finished query not strobed")

endmodule
